[rtl/differential_drive_odometry_defines.svh]
// Assertion macros for the odometry block, clocked on aclk and held off during reset.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH

// Condition that must hold at every edge.
`define DDO_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Antecedent at one edge, consequent at the next.
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ddo_pkg.sv]
// Shared types, constants and the CORDIC arctangent table for the odometry block.
package ddo_pkg;

    // radians Q.16 to 2^-32 turn
    localparam logic [29:0] RAD16_TO_TURN = 30'd683565276;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam int CORDIC_STEPS = 30;
    localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    typedef enum logic {
        SER_MUL,
        SER_DIV
    } ser_op_t;

    typedef struct packed {
        logic        start;
        ser_op_t     op;
        logic [47:0] opa;    // multiplicand or dividend
        logic [41:0] opb;    // multiplier or divisor
        logic [5:0]  steps;
    } ser_cmd_t;

    typedef struct packed {
        logic        done;
        logic [47:0] value;  // product mod 2^48 or quotient
    } ser_res_t;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;  // 2^-32 turn
    } cordic_cmd_t;

    typedef struct packed {
        logic               done;
        logic signed [33:0] cos_val;
        logic signed [33:0] sin_val;
    } cordic_res_t;

    // atan(2^-i) in 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

[rtl/ddo_serial.sv]
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
module ddo_serial import ddo_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  ser_cmd_t cmd,
    output ser_res_t res
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    ser_op_t     op_reg, op_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [47:0] acc_reg, acc_next;
    logic [47:0] a_reg, a_next;
    logic [41:0] b_reg, b_next;
    logic [41:0] rem_reg, rem_next;
    logic [41:0] trial;
    logic        fits;

    assign trial = {rem_reg[40:0], a_reg[47]};
    assign fits  = (trial >= b_reg);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        if (cmd.start) begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            cnt_next  = cmd.steps;
            acc_next  = '0;
            a_next    = cmd.opa;
            b_next    = cmd.opb;
            rem_next  = '0;
        end else if (busy_reg) begin
            unique case (op_reg)
                SER_MUL: begin
                    if (b_reg[0]) begin
                        acc_next = acc_reg + a_reg;
                    end
                    a_next = {a_reg[46:0], 1'b0};
                    b_next = {1'b0, b_reg[41:1]};
                end
                SER_DIV: begin
                    rem_next = fits ? (trial - b_reg) : trial;
                    a_next   = {a_reg[46:0], fits};
                end
            endcase
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
    end

    assign res.done  = done_reg;
    assign res.value = (op_reg == SER_MUL) ? acc_reg : a_reg;

endmodule

[rtl/ddo_cordic.sv]
// Iterative rotation CORDIC: cosine and sine of a binary angle, one micro-rotation per cycle.
module ddo_cordic import ddo_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cordic_cmd_t cmd,
    output cordic_res_t res
);

    localparam logic signed [33:0] QTR  = 34'sh0_4000_0000;
    localparam logic signed [33:0] HALF = 34'sh0_8000_0000;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [4:0]         iter_reg, iter_next;
    logic               flip_reg, flip_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic signed [33:0] cos_reg, cos_next;
    logic signed [33:0] sin_reg, sin_next;

    always_comb begin
        logic signed [33:0] zs;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [33:0] at;
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        flip_next = flip_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cos_next  = cos_reg;
        sin_next  = sin_reg;
        zs = 34'(signed'(cmd.angle));
        dx = y_reg >>> iter_reg;
        dy = x_reg >>> iter_reg;
        at = signed'({2'b00, atan_turn(iter_reg)});
        if (cmd.start) begin
            busy_next = 1'b1;
            iter_next = '0;
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            // fold into the right half-plane, negate at the end
            if (zs > QTR) begin
                z_next    = zs - HALF;
                flip_next = 1'b1;
            end else if (zs < -QTR) begin
                z_next    = zs + HALF;
                flip_next = 1'b1;
            end else begin
                z_next    = zs;
                flip_next = 1'b0;
            end
        end else if (busy_reg) begin
            if (!z_reg[33]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            iter_next = iter_reg + 5'd1;
            if (iter_reg == CORDIC_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                cos_next  = flip_reg ? -x_next : x_next;
                sin_next  = flip_reg ? -y_next : y_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        iter_reg <= iter_next;
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
    end

    assign res.done    = done_reg;
    assign res.cos_val = cos_reg;
    assign res.sin_val = sin_reg;

endmodule

[rtl/differential_drive_odometry.sv]
// Differential-drive odometry: pose update from wheel tick deltas along the exact arc.
//
//  channel   direction  handshake               payload
//  s_        in         s_valid / s_ready       s_left_ticks, s_right_ticks
//  m_        out        m_valid / m_ready       m_pos_x, m_pos_y, m_heading
//  cfg_      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item at a time. When the half turn is within the small-angle band, the first CORDIC
// pass and its divide are skipped. The work is shared between the bit-serial multiply/divide
// unit (one bit per cycle) and the 30-step CORDIC.
// Reset (aresetn low, synchronous) zeroes the pose and loads the default scales and track.
// The result sits in an output register; a stalled m_ready holds only the final copy-out.
// cfg_ready is always high; an index of 3 is ignored.
module differential_drive_odometry import ddo_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_left_ticks,
    input  logic signed [15:0] s_right_ticks,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic        [15:0] m_heading,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [1:0]  cfg_index,
    input  logic        [23:0] cfg_data
);

    `include "differential_drive_odometry_defines.svh"

    localparam logic [1:0] REG_LEFT_SCALE  = 2'd0;
    localparam logic [1:0] REG_RIGHT_SCALE = 2'd1;
    localparam logic [1:0] REG_TRACK_WIDTH = 2'd2;

    localparam logic [5:0] STEPS_SCALE = 6'd24;
    localparam logic [5:0] STEPS_TURN  = 6'd30;
    localparam logic [5:0] STEPS_DIV   = 6'd48;
    localparam logic [5:0] STEPS_HI    = 6'd17;
    localparam logic [5:0] STEPS_LO    = 6'd15;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_L,   // left distance
        S_MUL_R,   // right distance, then sum and difference
        S_DIV_Q,   // turn = diff / track
        S_MUL_G,   // half turn to binary angle
        S_MUL_T,   // full turn to binary angle
        S_CORD_K,  // sin of half turn
        S_DIV_K,   // chord factor
        S_LEN1,
        S_LEN2,
        S_CORD_P,  // cos/sin at mid-arc heading
        S_X1,
        S_X2,
        S_Y1,
        S_Y2,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    ser_cmd_t           cmd_reg, cmd_next;
    cordic_cmd_t        ccmd_reg, ccmd_next;
    ser_res_t           sres;
    cordic_res_t        cres;

    logic [23:0]        left_scale_reg, left_scale_next;
    logic [23:0]        right_scale_reg, right_scale_next;
    logic [15:0]        track_width_reg, track_width_next;

    logic signed [15:0] tr_reg, tr_next;
    logic signed [41:0] dl_reg, dl_next;
    logic signed [41:0] sum_reg, sum_next;
    logic               diff_neg_reg, diff_neg_next;
    logic signed [41:0] q_reg, q_next;
    logic [41:0]        hq_mag_reg, hq_mag_next;
    logic [31:0]        g_reg, g_next;
    logic [31:0]        t_reg, t_next;
    logic               s_neg_reg, s_neg_next;
    logic [31:0]        ua_reg, ua_next;
    logic [31:0]        ub_reg, ub_next;
    logic               neg_reg, neg_next;
    logic [32:0]        p1_reg, p1_next;
    logic [31:0]        len_mag_reg, len_mag_next;
    logic               len_neg_reg, len_neg_next;

    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic [15:0]        head_reg, head_next;

    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] m_pos_x_reg, m_pos_x_next;
    logic signed [31:0] m_pos_y_reg, m_pos_y_next;
    logic [15:0]        m_heading_reg, m_heading_next;

    // high half of a Q30 product: ua * (ub >> 15)
    function automatic ser_cmd_t mq_hi(input logic [31:0] ua, input logic [31:0] ub);
        ser_cmd_t c;
        c.start = 1'b1;
        c.op    = SER_MUL;
        c.opa   = 48'(ua);
        c.opb   = 42'(ub[31:15]);
        c.steps = STEPS_HI;
        return c;
    endfunction

    // magnitude of a CORDIC output, clamped to 2^31
    function automatic logic [31:0] mag_clamp(input logic signed [33:0] v);
        logic [33:0] m;
        m = v[33] ? 34'(-v) : 34'(v);
        return (m > 34'h0_8000_0000) ? 32'h8000_0000 : m[31:0];
    endfunction

    // add a signed delta to a position, saturating to 32 bits
    function automatic logic signed [31:0] sat_acc(input logic signed [31:0] acc,
                                                   input logic [32:0] r,
                                                   input logic neg);
        logic signed [34:0] d;
        logic signed [34:0] s;
        d = neg ? -signed'({2'b00, r}) : signed'({2'b00, r});
        s = 35'(acc) + d;
        if (s > 35'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (s < -35'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    ddo_serial u_serial (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd_reg),
        .res     (sres)
    );

    ddo_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ccmd_reg),
        .res     (cres)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        logic signed [41:0] dr;
        logic signed [41:0] diff;
        logic [41:0]        diff_mag;
        logic [41:0]        trk;
        logic [41:0]        qm;
        logic [41:0]        hqm;
        logic signed [41:0] hq_s;
        logic [41:0]        sum_mag;
        logic [33:0]        smag;
        logic [31:0]        ubk;
        logic [32:0]        r;
        logic [31:0]        fine;

        state_next       = state_reg;
        cmd_next         = cmd_reg;
        cmd_next.start   = 1'b0;
        ccmd_next        = ccmd_reg;
        ccmd_next.start  = 1'b0;
        left_scale_next  = left_scale_reg;
        right_scale_next = right_scale_reg;
        track_width_next = track_width_reg;
        tr_next          = tr_reg;
        dl_next          = dl_reg;
        sum_next         = sum_reg;
        diff_neg_next    = diff_neg_reg;
        q_next           = q_reg;
        hq_mag_next      = hq_mag_reg;
        g_next           = g_reg;
        t_next           = t_reg;
        s_neg_next       = s_neg_reg;
        ua_next          = ua_reg;
        ub_next          = ub_reg;
        neg_next         = neg_reg;
        p1_next          = p1_reg;
        len_mag_next     = len_mag_reg;
        len_neg_next     = len_neg_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        head_next        = head_reg;
        m_valid_next     = m_valid_reg;
        m_pos_x_next     = m_pos_x_reg;
        m_pos_y_next     = m_pos_y_reg;
        m_heading_next   = m_heading_reg;

        dr       = signed'(sres.value[41:0]);
        diff     = dr - dl_reg;
        diff_mag = diff[41] ? 42'(-diff) : 42'(diff);
        // a zero track behaves as one
        trk      = (track_width_reg == 16'd0) ? 42'd1 : 42'(track_width_reg);
        qm       = sres.value[41:0];
        hqm      = {1'b0, qm[41:1]};
        hq_s     = diff_neg_reg ? signed'(-hqm) : signed'(hqm);
        sum_mag  = sum_reg[41] ? 42'(-sum_reg) : 42'(sum_reg);
        smag     = cres.sin_val[33] ? 34'(-cres.sin_val) : 34'(cres.sin_val);
        // chord factor never above one
        ubk      = (sres.value > 48'(ONE_Q30)) ? ONE_Q30 : sres.value[31:0];
        // second partial product lands 30 bits down, the first 15
        r        = p1_reg + 33'(sres.value[47:30]);
        fine     = {head_reg, 16'h0000} + t_reg + 32'h0000_8000;

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_LEFT_SCALE:  left_scale_next  = cfg_data;
                REG_RIGHT_SCALE: right_scale_next = cfg_data;
                REG_TRACK_WIDTH: track_width_next = cfg_data[15:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    tr_next  = s_right_ticks;
                    cmd_next = '{start: 1'b1, op: SER_MUL, opa: 48'(s_left_ticks),
                                 opb: 42'(left_scale_reg), steps: STEPS_SCALE};
                    state_next = S_MUL_L;
                end
            end
            S_MUL_L: begin
                if (sres.done) begin
                    dl_next  = signed'(sres.value[41:0]);
                    cmd_next = '{start: 1'b1, op: SER_MUL, opa: 48'(tr_reg),
                                 opb: 42'(right_scale_reg), steps: STEPS_SCALE};
                    state_next = S_MUL_R;
                end
            end
            S_MUL_R: begin
                if (sres.done) begin
                    sum_next      = dl_reg + dr;
                    diff_neg_next = diff[41];
                    cmd_next = '{start: 1'b1, op: SER_DIV, opa: 48'(diff_mag),
                                 opb: trk, steps: STEPS_DIV};
                    state_next = S_DIV_Q;
                end
            end
            S_DIV_Q: begin
                if (sres.done) begin
                    q_next      = diff_neg_reg ? signed'(-qm) : signed'(qm);
                    hq_mag_next = hqm;
                    ua_next     = sum_mag[40:9];
                    cmd_next = '{start: 1'b1, op: SER_MUL, opa: 48'(hq_s),
                                 opb: 42'(RAD16_TO_TURN), steps: STEPS_TURN};
                    state_next = S_MUL_G;
                end
            end
            S_MUL_G: begin
                if (sres.done) begin
                    g_next   = sres.value[47:16];
                    cmd_next = '{start: 1'b1, op: SER_MUL, opa: 48'(q_reg),
                                 opb: 42'(RAD16_TO_TURN), steps: STEPS_TURN};
                    state_next = S_MUL_T;
                end
            end
            S_MUL_T: begin
                if (sres.done) begin
                    t_next = sres.value[47:16];
                    if (hq_mag_reg <= 42'd256) begin
                        // small angle or straight: chord factor is exactly one
                        ub_next    = ONE_Q30;
                        neg_next   = sum_reg[41];
                        cmd_next   = mq_hi(ua_reg, ONE_Q30);
                        state_next = S_LEN1;
                    end else begin
                        ccmd_next.start = 1'b1;
                        ccmd_next.angle = g_reg;
                        state_next      = S_CORD_K;
                    end
                end
            end
            S_CORD_K: begin
                if (cres.done) begin
                    s_neg_next = cres.sin_val[33];
                    cmd_next = '{start: 1'b1, op: SER_DIV, opa: {smag[31:0], 16'h0000},
                                 opb: hq_mag_reg, steps: STEPS_DIV};
                    state_next = S_DIV_K;
                end
            end
            S_DIV_K: begin
                if (sres.done) begin
                    ub_next    = ubk;
                    neg_next   = sum_reg[41] ^ s_neg_reg ^ diff_neg_reg;
                    cmd_next   = mq_hi(ua_reg, ubk);
                    state_next = S_LEN1;
                end
            end
            S_LEN1, S_X1, S_Y1: begin
                if (sres.done) begin
                    p1_next  = sres.value[47:15];
                    cmd_next = '{start: 1'b1, op: SER_MUL, opa: 48'(ua_reg),
                                 opb: 42'(ub_reg[14:0]), steps: STEPS_LO};
                    case (state_reg)
                        S_LEN1:  state_next = S_LEN2;
                        S_X1:    state_next = S_X2;
                        default: state_next = S_Y2;
                    endcase
                end
            end
            S_LEN2: begin
                if (sres.done) begin
                    len_mag_next    = r[31:0];
                    len_neg_next    = neg_reg;
                    ccmd_next.start = 1'b1;
                    ccmd_next.angle = {head_reg, 16'h0000} + g_reg;
                    state_next      = S_CORD_P;
                end
            end
            S_CORD_P: begin
                if (cres.done) begin
                    ua_next    = len_mag_reg;
                    ub_next    = mag_clamp(cres.cos_val);
                    neg_next   = len_neg_reg ^ cres.cos_val[33];
                    cmd_next   = mq_hi(len_mag_reg, mag_clamp(cres.cos_val));
                    state_next = S_X1;
                end
            end
            S_X2: begin
                if (sres.done) begin
                    x_next     = sat_acc(x_reg, r, neg_reg);
                    ub_next    = mag_clamp(cres.sin_val);
                    neg_next   = len_neg_reg ^ cres.sin_val[33];
                    cmd_next   = mq_hi(len_mag_reg, mag_clamp(cres.sin_val));
                    state_next = S_Y1;
                end
            end
            S_Y2: begin
                if (sres.done) begin
                    y_next     = sat_acc(y_reg, r, neg_reg);
                    head_next  = fine[31:16];
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_pos_x_next   = x_reg;
                    m_pos_y_next   = y_reg;
                    m_heading_next = head_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            cmd_reg         <= '0;
            ccmd_reg        <= '0;
            left_scale_reg  <= 24'd273296;
            right_scale_reg <= 24'd254447;
            track_width_reg <= 16'd3814;
            x_reg           <= '0;
            y_reg           <= '0;
            head_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            ccmd_reg        <= ccmd_next;
            left_scale_reg  <= left_scale_next;
            right_scale_reg <= right_scale_next;
            track_width_reg <= track_width_next;
            x_reg           <= x_next;
            y_reg           <= y_next;
            head_reg        <= head_next;
            m_valid_reg     <= m_valid_next;
        end
        tr_reg        <= tr_next;
        dl_reg        <= dl_next;
        sum_reg       <= sum_next;
        diff_neg_reg  <= diff_neg_next;
        q_reg         <= q_next;
        hq_mag_reg    <= hq_mag_next;
        g_reg         <= g_next;
        t_reg         <= t_next;
        s_neg_reg     <= s_neg_next;
        ua_reg        <= ua_next;
        ub_reg        <= ub_next;
        neg_reg       <= neg_next;
        p1_reg        <= p1_next;
        len_mag_reg   <= len_mag_next;
        len_neg_reg   <= len_neg_next;
        m_pos_x_reg   <= m_pos_x_next;
        m_pos_y_reg   <= m_pos_y_next;
        m_heading_reg <= m_heading_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_pos_x   = m_pos_x_reg;
    assign m_pos_y   = m_pos_y_reg;
    assign m_heading = m_heading_reg;

    // one item in flight: an accepted transfer closes the input at once
    `DDO_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "input open while busy")
    // a result appears only from the copy-out state
    `DDO_ASSERT_NEXT(a_out_source, state_reg != S_OUT, !$rose(m_valid_reg), "stray result")
    // the two shared units are never both finishing
    `DDO_ASSERT_NOW(a_unit_excl, !(sres.done && cres.done), "both units done together")
    // the heading moves only while an item is being worked
    `DDO_ASSERT_NEXT(a_head_idle, state_reg == S_IDLE, $stable(head_reg), "heading moved idle")

endmodule

[tb/testbench.sv]
// Self-checking testbench for the differential-drive odometry block.
`timescale 1ns / 1ps

module testbench;
    import ddo_pkg::*;

    localparam int  TIMEOUT_CYCLES = 3000000;
    localparam int  SETTLE_CYCLES  = 40;
    localparam int  REPORT_LIMIT   = 10;
    localparam longint Q30_ONE     = 64'sd1 << 30;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam bit [63:0] TURN_PER_RAD16 = 64'd683565276;

    // register indexes
    localparam logic [1:0] REG_LEFT_SCALE  = 2'd0;
    localparam logic [1:0] REG_RIGHT_SCALE = 2'd1;
    localparam logic [1:0] REG_TRACK       = 2'd2;
    localparam logic [1:0] REG_UNUSED      = 2'd3;

    // sender / receiver idling schemes
    localparam int IDLE_SEND_LIGHT = 0;
    localparam int IDLE_SEND_HEAVY = 1;
    localparam int IDLE_NONE       = 2;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } ticks_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic        [15:0] hdg;
    } pose_t;

    localparam bit [31:0] ATAN_TBL [30] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_left_ticks;
    logic signed [15:0] s_right_ticks;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_pos_x;
    logic signed [31:0] m_pos_y;
    logic        [15:0] m_heading;
    logic               cfg_valid;
    logic               cfg_ready;
    logic        [1:0]  cfg_index;
    logic        [23:0] cfg_data;

    differential_drive_odometry u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_left_ticks  (s_left_ticks),
        .s_right_ticks (s_right_ticks),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_heading     (m_heading),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    // pending tick pairs, expected poses and check counters
    ticks_t tick_queue[$];
    pose_t  pose_queue[$];
    int     mismatches;
    int     cycle_count;
    int     idle_scheme;
    bit     hold_sender;

    // shadow of the block's configuration and pose
    bit [23:0] sh_left_scale;
    bit [23:0] sh_right_scale;
    bit [15:0] sh_track;
    longint    sh_x;
    longint    sh_y;
    bit [15:0] sh_hdg;

    // radians Q.16 to 2^-32 turn, floor, mod 2^32
    function automatic bit [31:0] rad_to_turns(longint v);
        bit [63:0] uv;
        bit [63:0] lo;
        bit [63:0] hi;
        uv = v;
        lo = uv & 64'hFFFF;
        hi = (uv - lo) >> 16;
        return 32'(hi * TURN_PER_RAD16 + ((lo * TURN_PER_RAD16) >> 16));
    endfunction

    // 30-step rotation; results scaled by 2^30
    function automatic void sincos(input bit [31:0] ang, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = longint'(ang);
        x = GAIN_Q30;
        y = 0;
        flip = 0;
        if (z >= (64'sd1 << 31)) z = z - (64'sd1 << 32);
        if (z > (64'sd1 << 30)) begin
            z = z - (64'sd1 << 31);
            flip = 1;
        end else if (z < -(64'sd1 << 30)) begin
            z = z + (64'sd1 << 31);
            flip = 1;
        end
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TBL[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TBL[i]);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    // (a * b) / 2^30 toward zero, two partial products, |b| capped at 2^31
    function automatic longint scale_q30(longint a, longint b);
        bit        neg;
        bit [63:0] ua;
        bit [63:0] ub;
        bit [63:0] r;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        if (ub > (64'd1 << 31)) ub = 64'd1 << 31;
        r = ((ua * (ub >> 15)) >> 15) + ((ua * (ub & 64'h7FFF)) >> 30);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // advance the shadow pose by one tick pair and return the new pose
    function automatic pose_t advance_pose(ticks_t t);
        longint    dl;
        longint    dr;
        longint    trk;
        longint    turn;
        longint    half;
        longint    k;
        longint    c;
        longint    s;
        longint    len;
        bit [31:0] half_ang;
        bit [31:0] hf;
        bit [31:0] fine;
        pose_t     p;
        dl = longint'(t.left) * longint'(sh_left_scale);
        dr = longint'(t.right) * longint'(sh_right_scale);
        trk = (sh_track == 0) ? 1 : longint'(sh_track);
        turn = (dr - dl) / trk;
        half = turn / 2;
        half_ang = rad_to_turns(half);
        // chord factor sin(h)/h, exactly one inside the small-angle band
        if (half <= 256 && half >= -256) begin
            k = Q30_ONE;
        end else begin
            sincos(half_ang, c, s);
            k = (s * 65536) / half;
            if (k > Q30_ONE) k = Q30_ONE;
            if (k < -Q30_ONE) k = -Q30_ONE;
        end
        len = scale_q30((dl + dr) / 512, k);
        hf = {sh_hdg, 16'h0};
        sincos(hf + half_ang, c, s);
        sh_x = clamp32(sh_x + scale_q30(len, c));
        sh_y = clamp32(sh_y + scale_q30(len, s));
        fine = hf + rad_to_turns(turn) + 32'h8000;
        sh_hdg = fine[31:16];
        p.x = sh_x[31:0];
        p.y = sh_y[31:0];
        p.hdg = sh_hdg;
        return p;
    endfunction

    // sender: next pair goes out once the current one has been taken
    always @(posedge aclk) begin
        if (aresetn && (!s_valid || s_ready)) begin
            if (hold_sender || tick_queue.size() == 0 ||
                (idle_scheme == IDLE_SEND_LIGHT && $urandom_range(0, 99) < 33) ||
                (idle_scheme == IDLE_SEND_HEAVY && $urandom_range(0, 99) < 76)) begin
                s_valid <= 1'b0;
            end else begin
                ticks_t t;
                t = tick_queue.pop_front();
                s_valid       <= 1'b1;
                s_left_ticks  <= t.left;
                s_right_ticks <= t.right;
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        case (idle_scheme)
            IDLE_SEND_LIGHT: m_ready <= ($urandom_range(0, 99) >= 76);
            IDLE_SEND_HEAVY: m_ready <= ($urandom_range(0, 99) >= 33);
            default:         m_ready <= 1'b1;
        endcase
    end

    // prediction on accepted transfers, checking of results, run timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LEFT_SCALE:  sh_left_scale  = cfg_data;
                    REG_RIGHT_SCALE: sh_right_scale = cfg_data;
                    REG_TRACK:       sh_track       = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                pose_queue.push_back(advance_pose('{s_left_ticks, s_right_ticks}));
            if (m_valid && m_ready) begin
                if (pose_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result x=%0d y=%0d hdg=%0d",
                                 m_pos_x, m_pos_y, m_heading);
                end else begin
                    pose_t e;
                    e = pose_queue.pop_front();
                    if (m_pos_x !== e.x || m_pos_y !== e.y || m_heading !== e.hdg) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"pose mismatch: exp x=%0d y=%0d hdg=%0d,",
                                      " got x=%0d y=%0d hdg=%0d"},
                                     e.x, e.y, e.hdg, m_pos_x, m_pos_y, m_heading);
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        while (tick_queue.size() != 0 || s_valid || pose_queue.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one register write transfer; only issued with the block idle
    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [23:0] ls, logic [23:0] rs, logic [15:0] trk);
        wait_drained();
        write_reg(REG_LEFT_SCALE, ls);
        write_reg(REG_RIGHT_SCALE, rs);
        write_reg(REG_TRACK, {8'h0, trk});
    endtask

    task automatic push_ticks(int l, int r);
        tick_queue.push_back('{16'(l), 16'(r)});
    endtask

    // mostly modest motion, some straight runs, some extremes and full-range noise
    task automatic push_random_ticks();
        int sel;
        int l;
        int r;
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            l = $urandom();
            r = $urandom();
        end else if (sel < 25) begin
            l = $urandom_range(0, 6000) - 3000;
            r = l;
        end else if (sel < 35) begin
            l = $urandom_range(0, 1) ? 32767 : -32768;
            r = $urandom_range(0, 2) == 0 ? l : ($urandom_range(0, 1) ? 32767 : -32768);
        end else if (sel < 50) begin
            l = $urandom_range(0, 400) - 200;
            r = l + $urandom_range(0, 6) - 3;
        end else begin
            l = $urandom_range(0, 6000) - 3000;
            r = $urandom_range(0, 6000) - 3000;
        end
        push_ticks(l, r);
    endtask

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_left_ticks  = '0;
        s_right_ticks = '0;
        m_ready     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_LEFT_SCALE;
        cfg_data    = '0;
        mismatches  = 0;
        cycle_count = 0;
        idle_scheme = IDLE_SEND_LIGHT;
        hold_sender = 1'b0;
        // reset values of the shadow
        sh_left_scale  = 24'd273296;
        sh_right_scale = 24'd254447;
        sh_track       = 16'd3814;
        sh_x   = 0;
        sh_y   = 0;
        sh_hdg = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: straight, tiny turn, spins, extremes, on reset configuration
        push_ticks(0, 0);
        push_ticks(100, 100);
        push_ticks(1, 0);
        push_ticks(10, 12);
        push_ticks(100, -100);
        push_ticks(-2000, 2000);
        push_ticks(32767, 32767);
        push_ticks(-32768, -32768);
        push_ticks(-32768, 32767);
        push_ticks(32767, -32768);
        push_ticks(5000, 0);

        // the pause: nothing new until every result is back
        wait_drained();
        hold_sender = 1'b1;
        push_ticks(300, 250);
        repeat (50) @(posedge aclk);
        hold_sender = 1'b0;

        // zero track, full scales; index 3 must change nothing
        set_config(24'hFFFFFF, 24'hFFFFFF, 16'd0);
        write_reg(REG_UNUSED, 24'h123456);
        push_ticks(32767, 32767);
        push_ticks(32767, 32767);
        push_ticks(1, -1);
        push_ticks(-32768, -32768);
        push_ticks(-32768, 32767);
        set_config(24'd0, 24'd0, 16'hFFFF);
        push_ticks(32767, -32768);
        push_ticks(-1, 1);
        set_config(24'd0, 24'hFFFFFF, 16'd1);
        push_ticks(0, 32767);
        push_ticks(0, -32768);

        // random part over the three idling schemes, settings changed now and then
        for (int n = 0; n < 900; n++) begin
            if (n == 300 || n == 600) begin
                wait_drained();
                idle_scheme = (n == 300) ? IDLE_SEND_HEAVY : IDLE_NONE;
            end
            if (n % 100 == 0) begin
                case ((n / 100) % 5)
                    0: set_config(24'd273296, 24'd254447, 16'd3814);
                    1: set_config(24'hFFFFFF, 24'hFFFFFF, 16'd1);
                    2: set_config(24'd0, 24'd0, 16'hFFFF);
                    3: set_config(24'($urandom()), 24'($urandom()),
                                  16'($urandom_range(0, 65535)));
                    default: set_config(24'($urandom_range(100000, 400000)),
                                        24'($urandom_range(100000, 400000)),
                                        16'($urandom_range(1000, 8000)));
                endcase
            end
            push_random_ticks();
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[differential_drive_odometry.f]
+incdir+rtl
rtl/ddo_pkg.sv
rtl/ddo_serial.sv
rtl/ddo_cordic.sv
rtl/differential_drive_odometry.sv
tb/testbench.sv
